// ===== sv/mcom_pkg.sv =====
// shared types and constants for the mosaic cell overlap merge block
package mcom_pkg;

  localparam logic [1:0] REQ_MERGE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] OVL_FIRST   = 3'd0;
  localparam logic [2:0] OVL_LAST    = 3'd1;
  localparam logic [2:0] OVL_MIN     = 3'd2;
  localparam logic [2:0] OVL_MAX     = 3'd3;
  localparam logic [2:0] OVL_MEAN    = 3'd4;
  localparam logic [2:0] OVL_BLEND   = 3'd5;
  localparam logic [2:0] OVL_FEATHER = 3'd6;

  localparam logic [1:0] MATCH_NONE = 2'd0;
  localparam logic [1:0] MATCH_REGR = 2'd1;
  localparam logic [1:0] MATCH_STD  = 2'd2;

  localparam logic [2:0] REG_OVERLAP = 3'd0;
  localparam logic [2:0] REG_MMODE   = 3'd1;
  localparam logic [2:0] REG_OFFSET  = 3'd2;
  localparam logic [2:0] REG_GAIN    = 3'd3;
  localparam logic [2:0] REG_CENTRE  = 3'd4;
  localparam logic [2:0] REG_FEATHER = 3'd5;

  localparam int QUO_W = 50;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_RD, ST_MUL, ST_MATCH, ST_MERGE, ST_M2, ST_DIV, ST_WB, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/mcom_div.sv =====
// serial floor divider, one quotient bit per cycle
module mcom_div
  import mcom_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] mag;
  logic [34:0] rem;
  logic [33:0] den;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [34:0] trial;
  logic [63:0] q_fix;

  assign trial = {rem[33:0], mag[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        neg  <= req.num[63];
        // floor for negatives: -((-n-1)/d)-1 = ~((~n)/d)
        mag  <= req.num[63] ? ~req.num : req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[34]) begin
          rem <= trial;
          mag <= {mag[62:0], 1'b1};
        end else begin
          rem <= {rem[33:0], mag[63]};
          mag <= {mag[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q_fix    = neg ? ~mag : mag;
  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = q_fix[QUO_W-1:0];

endmodule

// ===== sv/mosaic_cell_overlap_merge.sv =====
// top level: mosaic cell store with match, overlap merge and serial divider
// throughput: one item at a time; the next item is taken in the cycle after the
//   result is accepted, so the 64-step divider sets the worst case
// reset: after rst a clearing pass zeroes the store and the input stays not ready
//   until the last clearing write is in; configuration writes are taken as ever
module mosaic_cell_overlap_merge
  import mcom_pkg::*;
#(
  parameter int CELL_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // cell_index[11:0], sample_value[43:12], sample_weight[60:44]
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // cell_value[31:0], cell_valid[32], cell_weight[48:33], saturated[49]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam logic [12:0] CNT13 = 13'(CELL_COUNT > 4096 ? 4096 : CELL_COUNT);

  // configuration registers
  logic [2:0]         overlap_mode;
  logic [1:0]         match_mode;
  logic signed [31:0] match_offset;
  logic signed [23:0] match_gain;
  logic signed [31:0] match_centre;
  logic [15:0]        feather_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_mode     <= OVL_LAST;
      match_mode       <= MATCH_NONE;
      match_offset     <= '0;
      match_gain       <= 24'sd65536;
      match_centre     <= '0;
      feather_distance <= 16'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OVERLAP: overlap_mode     <= cfg_data[2:0];
        REG_MMODE:   match_mode       <= cfg_data[1:0];
        REG_OFFSET:  match_offset     <= cfg_data;
        REG_GAIN:    match_gain       <= cfg_data[23:0];
        REG_CENTRE:  match_centre     <= cfg_data;
        REG_FEATHER: feather_distance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // cell memory: value, valid, weight in one word
  logic [48:0] mem [CELL_COUNT];
  logic [48:0] rd_word;
  logic        we;
  logic [AW-1:0] waddr;
  logic [48:0] wdata;
  logic [AW-1:0] raddr;

  // item registers
  state_t state, state_next;
  logic [1:0]         req;
  logic [11:0]        idx;
  logic signed [31:0] sv;
  logic [16:0]        sw;
  logic [AW-1:0]      clr_addr;
  logic               clr_last;

  logic signed [31:0] cur;
  logic               cvalid;
  logic [15:0]        cw;
  logic signed [31:0] v;       // matched sample
  logic signed [63:0] prod;    // registered product
  logic signed [31:0] nval;
  logic               nvalid;
  logic [15:0]        nw;
  logic               sat;
  logic               in_range;
  logic [55:0]        out_data;

  div_req_t dreq;
  div_rsp_t drsp;
  mcom_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // merge datapath temporaries
  logic signed [33:0] mx;
  logic [16:0]        wf;
  logic signed [16:0] dd;
  logic signed [17:0] diff;
  logic signed [63:0] div_num;
  logic [33:0]        div_den;
  logic               go_div;
  logic               go_shift;
  logic signed [32:0] ssum;
  logic signed [31:0] dq_sat;
  logic signed [33:0] ma, mb;
  logic signed [63:0] mp;
  logic signed [63:0] mt;
  logic signed [63:0] cur_prod;

  function automatic logic signed [31:0] sat32(input logic signed [QUO_W-1:0] x);
    if (x > QUO_W'(64'sd2147483647)) return 32'sh7fffffff;
    if (x < -QUO_W'(64'sd2147483648)) return 32'sh80000000;
    return x[31:0];
  endfunction

  assign in_range = ({1'b0, idx} < CNT13);
  // held off while the last clearing write is still on its way into the store
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid && !we;
  assign dd = (feather_distance == 16'd0) ? 17'sd1 : $signed({1'b0, feather_distance});
  assign diff = $signed({1'b0, sw}) - $signed({2'b0, cw});
  assign wf = sw[16] ? 17'h10000 : sw;
  assign ssum = $signed({cur[31], cur}) + $signed({v[31], v});
  assign dq_sat = sat32(drsp.quo);

  // the cell is read at the accepting edge so its word is ready in ST_RD
  assign raddr = (s_axis_tvalid && s_axis_tready) ? AW'(s_axis_tdata[11:0]) : AW'(idx);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_word <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) clr_addr <= clr_addr + AW'(1);
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state == ST_OUT) m_axis_tvalid <= 1'b1;
    end
  end

  assign clr_last = (clr_addr == AW'(CELL_COUNT - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_next = ST_RD;
      ST_CLR:   if (clr_last) state_next = ST_IDLE;
      ST_RD:    state_next = !in_range ? ST_OUT : (req == REQ_MERGE) ? ST_MUL : ST_MERGE;
      ST_MUL:   state_next = ST_MATCH;
      ST_MATCH: state_next = ST_MERGE;
      ST_MERGE: state_next = go_div ? ST_DIV : go_shift ? ST_M2 : ST_WB;
      ST_M2:    state_next = ST_WB;
      ST_DIV:   if (drsp.done) state_next = ST_WB;
      ST_WB:    state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // merge and mean read decision: whether the blend shift or the divider is needed; also the match input
  always_comb begin
    go_div   = 1'b0;
    go_shift = 1'b0;
    div_num  = '0;
    div_den  = 34'd1;
    if (req == REQ_MERGE && cvalid) begin
      if (overlap_mode == OVL_BLEND) begin
        go_shift = 1'b1;
      end else if (overlap_mode == OVL_FEATHER && diff < 18'(dd) && diff > -18'(dd)) begin
        go_div  = 1'b1;
        // cur*(d-diff) + v*(d+diff) + d over 2d
        div_num = cur_prod + mp + 64'(dd);
        div_den = {16'd0, dd, 1'b0};
      end
    end else if (req != REQ_MERGE && req != REQ_CLEAR && overlap_mode == OVL_MEAN
                 && cw != 16'd0) begin
      go_div  = 1'b1;
      div_num = prod;
      div_den = {17'd0, cw, 1'b0};
    end
    mx   = (match_mode == MATCH_STD) ? ({sv[31], sv[31], sv} - {match_centre[31],
            match_centre[31], match_centre}) : {sv[31], sv[31], sv};
  end

  // one multiplier shared between match, blend, feather
  assign mp = ma * mb;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_MUL: begin
        ma = mx;
        mb = 34'(match_gain);
      end
      ST_MATCH: begin
        ma = $signed({cur[31], cur[31], cur});
        mb = (overlap_mode == OVL_BLEND) ? $signed(34'(18'sd65536 - $signed({1'b0, wf})))
                                         : 34'(18'(dd) - diff);
      end
      ST_MERGE: begin
        ma = $signed({v[31], v[31], v});
        mb = (overlap_mode == OVL_BLEND) ? $signed(34'({1'b0, wf}))
                                         : 34'(18'(dd) + diff);
      end
      default: ;
    endcase
  end

  assign mt = (mp + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    dreq.start <= (state == ST_MERGE) && go_div;
    we <= (state == ST_CLR) || (state == ST_WB && (req == REQ_MERGE || req == REQ_CLEAR));
    if (state == ST_CLR) begin
      waddr <= clr_addr;
      wdata <= '0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      req <= s_axis_tuser;
      idx <= s_axis_tdata[11:0];
      sv  <= s_axis_tdata[43:12];
      sw  <= s_axis_tdata[60:44];
      sat <= 1'b0;
    end
    unique case (state)
      ST_RD: begin
        cur    <= rd_word[31:0];
        cvalid <= rd_word[32];
        cw     <= rd_word[48:33];
        nval   <= rd_word[31:0];
        nvalid <= rd_word[32];
        nw     <= rd_word[48:33];
        v      <= sv;
        // mean read numerator 2*sum + count
        prod   <= ({{31{rd_word[31]}}, rd_word[31:0], 1'b0}) + 64'(rd_word[48:33]);
      end
      ST_MUL: begin
        if (match_mode == MATCH_REGR || match_mode == MATCH_STD)
          v <= sat32(QUO_W'(mt + 64'(match_offset)));
      end
      ST_MATCH: cur_prod <= mp;
      ST_MERGE: begin
        if (req == REQ_MERGE)
          prod <= cur_prod + mp + ((overlap_mode == OVL_BLEND) ? 64'sd32768 : 64'(dd));
        dreq.num <= div_num;
        dreq.den <= div_den;
        if (req == REQ_CLEAR) begin
          nval <= '0; nvalid <= 1'b0; nw <= '0;
        end else if (req == REQ_MERGE) begin
          priority case (overlap_mode)
            OVL_FIRST: if (!cvalid) begin nval <= v; nvalid <= 1'b1; end
            OVL_LAST:  begin nval <= v; nvalid <= 1'b1; end
            OVL_MIN:   if (!cvalid || cur > v) begin nval <= v; nvalid <= 1'b1; end
            OVL_MAX:   if (!cvalid || cur < v) begin nval <= v; nvalid <= 1'b1; end
            OVL_MEAN: begin
              nvalid <= 1'b1;
              if (!cvalid) begin
                nval <= v; nw <= 16'd1;
              end else begin
                nval <= sat32(QUO_W'(ssum));
                sat  <= (ssum != 33'(sat32(QUO_W'(ssum)))) || (cw == 16'hffff);
                if (cw != 16'hffff) nw <= cw + 16'd1;
              end
            end
            OVL_BLEND: if (!cvalid) begin nval <= v; nvalid <= 1'b1; end
            OVL_FEATHER: begin
              if (!cvalid || diff >= 18'(dd)) begin
                nval <= v; nvalid <= 1'b1;
                nw <= sw[16] ? 16'hffff : sw[15:0];
              end else if (diff > -18'(dd) && diff > 18'sd0) begin
                nw <= sw[16] ? 16'hffff : sw[15:0];
              end
            end
            default: ;
          endcase
        end
      end
      // blend divides by 65536: floor is an arithmetic shift
      ST_M2: nval <= sat32(QUO_W'(prod >>> 16));
      ST_DIV: if (drsp.done) nval <= dq_sat;
      ST_WB: begin
        if (req == REQ_MERGE || req == REQ_CLEAR) begin
          waddr <= AW'(idx);
          // a mean read result is not written back
          wdata <= {nw, nvalid, (req == REQ_MERGE) ? nval : 32'd0};
        end
      end
      default: ;
    endcase
    if (state == ST_OUT) m_axis_tdata <= out_data;
  end

  always_comb begin
    out_data = '0;
    if (in_range) begin
      out_data[31:0]  = nvalid ? nval : 32'd0;
      out_data[32]    = nvalid;
      out_data[48:33] = nw;
      out_data[49]    = sat;
    end
  end

  // output must not be raised while a result is still pending
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> !m_axis_tvalid || m_axis_tready)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !drsp.busy)
    else $error("divider busy while idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> !s_axis_tready)
    else $error("input taken during clear pass");

endmodule
